FILE: rtl/trc16_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package trc16_pkg;

  localparam int ADDR_BITS = 16;
  localparam int MEM_WORDS = 1 << ADDR_BITS;

  localparam logic [15:0] HALT_WORD     = 16'hFFFF;
  localparam logic [15:0] STACK_RESET   = 16'h8000;
  localparam logic [15:0] PORT_IN_CHAR  = 16'hF000;
  localparam logic [15:0] PORT_IN_NUM   = 16'hF001;
  localparam logic [15:0] PORT_OUT_CHAR = 16'hF002;
  localparam logic [15:0] PORT_OUT_NUM  = 16'hF003;

  localparam logic [3:0] SP_IDX = 4'd14;
  localparam logic [3:0] PC_IDX = 4'd15;

  localparam logic [1:0] PORT_NONE = 2'd0;
  localparam logic [1:0] PORT_CHAR = 2'd1;
  localparam logic [1:0] PORT_NUM  = 2'd2;

  localparam logic [2:0] COND_AL = 3'd0;
  localparam logic [2:0] COND_EQ = 3'd1;
  localparam logic [2:0] COND_NE = 3'd2;
  localparam logic [2:0] COND_HI = 3'd3;
  localparam logic [2:0] COND_LS = 3'd7;

  typedef enum logic [3:0] {
    OP_JMP  = 4'h0,
    OP_NOP  = 4'h1,
    OP_LDR  = 4'h2,
    OP_STR  = 4'h3,
    OP_MOV  = 4'h4,
    OP_ADD  = 4'h5,
    OP_ADDI = 4'h6,
    OP_SUB  = 4'h7,
    OP_SUBI = 4'h8,
    OP_AND  = 4'h9,
    OP_OR   = 4'hA,
    OP_SHR  = 4'hB,
    OP_SHL  = 4'hC,
    OP_CMP  = 4'hD,
    OP_PUSH = 4'hE,
    OP_POP  = 4'hF
  } op_t;

  typedef struct packed {
    logic                 re;
    logic [ADDR_BITS-1:0] raddr;
    logic                 we;
    logic [ADDR_BITS-1:0] waddr;
    logic [15:0]          wdata;
  } mem_req_t;

  typedef struct packed {
    logic        re;
    logic [3:0]  raddr_a;
    logic [3:0]  raddr_b;
    logic        we;
    logic [3:0]  waddr;
    logic [15:0] wdata;
  } rf_req_t;

  typedef struct packed {
    logic [15:0] res;
    logic        z;
    logic        c;
  } alu_out_t;

  // true when the address maps onto a physical memory word
  function automatic logic in_range(input logic [15:0] a);
    return (({16'd0, a} >> ADDR_BITS) == 32'd0);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/trc16_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module trc16_mem (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire trc16_pkg::mem_req_t req,
  output logic [15:0]              rdata,
  output logic                     clearing
);

  logic [15:0] mem [trc16_pkg::MEM_WORDS];
  logic [trc16_pkg::ADDR_BITS-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == '1) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= 16'd0;
    end else if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/trc16_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module trc16_regs (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire trc16_pkg::rf_req_t req,
  output logic [15:0]             rdata_a,
  output logic [15:0]             rdata_b
);

  logic [15:0] rf [16];
  logic [15:0] valid;
  logic [15:0] q_a;
  logic [15:0] q_b;
  logic        v_a;
  logic        v_b;
  logic [3:0]  idx_a;
  logic [3:0]  idx_b;

  function automatic logic [15:0] reset_val(input logic [3:0] idx);
    return (idx == trc16_pkg::SP_IDX) ? trc16_pkg::STACK_RESET : 16'd0;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (req.we) begin
      valid[req.waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.we) begin
      rf[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      q_a   <= rf[req.raddr_a];
      q_b   <= rf[req.raddr_b];
      v_a   <= valid[req.raddr_a];
      v_b   <= valid[req.raddr_b];
      idx_a <= req.raddr_a;
      idx_b <= req.raddr_b;
    end
  end

  // entries never written since reset read as their reset value
  assign rdata_a = v_a ? q_a : reset_val(idx_a);
  assign rdata_b = v_b ? q_b : reset_val(idx_b);

endmodule

`default_nettype wire

FILE: rtl/trc16_alu.sv
`timescale 1ns / 1ps
`default_nettype none

module trc16_alu (
  input  wire trc16_pkg::op_t  op,
  input  wire logic [15:0]     a,
  input  wire logic [15:0]     b,
  input  wire logic [3:0]      imm,
  output trc16_pkg::alu_out_t  out
);

  logic [15:0] res;

  always_comb begin
    case (op)
      trc16_pkg::OP_ADD:  res = a + b;
      trc16_pkg::OP_ADDI: res = a + {12'd0, imm};
      trc16_pkg::OP_SUB:  res = a - b;
      trc16_pkg::OP_SUBI: res = a - {12'd0, imm};
      trc16_pkg::OP_AND:  res = a & b;
      trc16_pkg::OP_OR:   res = a | b;
      trc16_pkg::OP_SHR:  res = a >> imm;
      trc16_pkg::OP_SHL:  res = a << imm;
      trc16_pkg::OP_CMP:  res = a - b;
      default:            res = 16'd0;
    endcase
  end

  assign out.res = res;
  assign out.z   = (res == 16'd0);
  assign out.c   = (res < a);

endmodule

`default_nettype wire

FILE: rtl/tiny_risc16_core_step.sv
`timescale 1ns / 1ps
`default_nettype none

// Small 16-bit core, one command per item: cmd 0 writes one memory word, cmd 1 runs one
// instruction. An item is taken when start is high and busy is low; its result shows for
// exactly one cycle with done high and must be taken then, since there is no way to hold
// it. A load is written when it is taken. A step ends at decode on a halt word, after
// execute for most instructions, after the data access for LDR and for POP into R14, and
// after a second stack pointer write for other POPs: fetch, register read and data access
// each wait on a synchronous memory with registered read data, and a POP into any other
// register needs that second register file write. After reset busy stays high while the
// main memory is cleared, one word per cycle.
module tiny_risc16_core_step (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        cmd,
  input  wire logic [15:0] load_address,
  input  wire logic [15:0] load_value,
  input  wire logic [15:0] io_in,
  output logic             done,
  output logic             halted,
  output logic [15:0]      program_counter,
  output logic [1:0]       input_port_used,
  output logic [1:0]       output_port,
  output logic [15:0]      output_value,
  output logic             zero_flag,
  output logic             carry_flag
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_EXEC,
    S_MEM,
    S_WB2
  } state_t;

  state_t state;

  trc16_pkg::mem_req_t mreq;
  trc16_pkg::rf_req_t  rreq;
  trc16_pkg::alu_out_t alu;
  trc16_pkg::op_t      op;

  logic        clearing;
  logic [15:0] mem_rdata;
  logic [15:0] rf_a;
  logic [15:0] rf_b;

  logic [15:0] pc;
  logic        z;
  logic        c;
  logic [15:0] ir;
  logic        rd_oor;
  logic [15:0] io_val;
  logic [15:0] daddr;
  logic [1:0]  port_rd;

  logic        accept;
  logic [15:0] word_in;
  logic [3:0]  rd;
  logic [3:0]  rm;
  logic [3:0]  rn;
  logic [3:0]  a_idx;
  logic [3:0]  dec_a_idx;
  logic [15:0] a;
  logic [15:0] b;
  logic [15:0] sp_dec;
  logic [15:0] push_data;
  logic [15:0] ld_addr;
  logic [15:0] ld_val;
  logic [15:0] ofs;
  logic        take;
  logic        wb_en;
  logic [3:0]  wb_idx;
  logic [15:0] wb_val;

  function automatic logic [1:0] in_code(input logic [15:0] addr);
    if (addr == trc16_pkg::PORT_IN_CHAR) begin
      return trc16_pkg::PORT_CHAR;
    end else if (addr == trc16_pkg::PORT_IN_NUM) begin
      return trc16_pkg::PORT_NUM;
    end
    return trc16_pkg::PORT_NONE;
  endfunction

  function automatic logic [1:0] out_code(input logic [15:0] addr);
    if (addr == trc16_pkg::PORT_OUT_CHAR) begin
      return trc16_pkg::PORT_CHAR;
    end else if (addr == trc16_pkg::PORT_OUT_NUM) begin
      return trc16_pkg::PORT_NUM;
    end
    return trc16_pkg::PORT_NONE;
  endfunction

  trc16_mem u_mem (
    .clk      (clk),
    .rst      (rst),
    .req      (mreq),
    .rdata    (mem_rdata),
    .clearing (clearing)
  );

  trc16_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .req     (rreq),
    .rdata_a (rf_a),
    .rdata_b (rf_b)
  );

  trc16_alu u_alu (
    .op  (op),
    .a   (a),
    .b   (b),
    .imm (rn),
    .out (alu)
  );

  assign busy   = clearing || (state != S_IDLE);
  assign accept = start && !busy;

  assign program_counter = pc;
  assign zero_flag       = z;
  assign carry_flag      = c;

  // fetched word or data word, zero beyond the physical memory
  assign word_in = rd_oor ? 16'd0 : mem_rdata;

  assign op = trc16_pkg::op_t'(ir[15:12]);
  assign rd = ir[11:8];
  assign rm = ir[7:4];
  assign rn = ir[3:0];

  assign dec_a_idx = ((word_in[15:12] == trc16_pkg::OP_PUSH) ||
                      (word_in[15:12] == trc16_pkg::OP_POP)) ? trc16_pkg::SP_IDX : word_in[7:4];
  assign a_idx     = ((op == trc16_pkg::OP_PUSH) || (op == trc16_pkg::OP_POP)) ?
                     trc16_pkg::SP_IDX : rm;

  // R15 lives in pc, already advanced past the instruction
  assign a = (a_idx == trc16_pkg::PC_IDX) ? pc : rf_a;
  assign b = (rn == trc16_pkg::PC_IDX) ? pc : rf_b;

  assign sp_dec    = a - 16'd1;
  assign push_data = (rn == trc16_pkg::SP_IDX) ? sp_dec : b;
  assign ld_addr   = (op == trc16_pkg::OP_POP) ? a : b;
  assign ld_val    = (port_rd != trc16_pkg::PORT_NONE) ? io_val : word_in;
  assign ofs       = {{6{ir[9]}}, ir[9:0]};

  always_comb begin
    case (ir[12:10])
      trc16_pkg::COND_AL: take = 1'b1;
      trc16_pkg::COND_EQ: take = z;
      trc16_pkg::COND_NE: take = !z;
      trc16_pkg::COND_HI: take = !z && c;
      trc16_pkg::COND_LS: take = z || !c;
      default:            take = 1'b0;
    endcase
  end

  always_comb begin
    mreq   = '0;
    rreq   = '0;
    wb_en  = 1'b0;
    wb_idx = rd;
    wb_val = 16'd0;
    case (state)
      S_IDLE: begin
        if (accept && !cmd) begin
          mreq.we    = trc16_pkg::in_range(load_address);
          mreq.waddr = load_address[trc16_pkg::ADDR_BITS-1:0];
          mreq.wdata = load_value;
        end else if (accept) begin
          mreq.re    = 1'b1;
          mreq.raddr = pc[trc16_pkg::ADDR_BITS-1:0];
        end
      end
      S_DECODE: begin
        rreq.re      = (word_in != trc16_pkg::HALT_WORD);
        rreq.raddr_a = dec_a_idx;
        rreq.raddr_b = word_in[3:0];
      end
      S_EXEC: begin
        case (op)
          trc16_pkg::OP_LDR, trc16_pkg::OP_POP: begin
            mreq.re    = 1'b1;
            mreq.raddr = ld_addr[trc16_pkg::ADDR_BITS-1:0];
          end
          trc16_pkg::OP_STR: begin
            mreq.we    = (out_code(a) == trc16_pkg::PORT_NONE) && trc16_pkg::in_range(a);
            mreq.waddr = a[trc16_pkg::ADDR_BITS-1:0];
            mreq.wdata = b;
          end
          trc16_pkg::OP_PUSH: begin
            wb_en      = 1'b1;
            wb_idx     = trc16_pkg::SP_IDX;
            wb_val     = sp_dec;
            mreq.we    = (out_code(sp_dec) == trc16_pkg::PORT_NONE) &&
                         trc16_pkg::in_range(sp_dec);
            mreq.waddr = sp_dec[trc16_pkg::ADDR_BITS-1:0];
            mreq.wdata = push_data;
          end
          trc16_pkg::OP_MOV: begin
            wb_en  = 1'b1;
            wb_val = {8'd0, ir[7:0]};
          end
          trc16_pkg::OP_ADD, trc16_pkg::OP_ADDI, trc16_pkg::OP_SUB, trc16_pkg::OP_SUBI,
          trc16_pkg::OP_AND, trc16_pkg::OP_OR, trc16_pkg::OP_SHR, trc16_pkg::OP_SHL: begin
            wb_en  = 1'b1;
            wb_val = alu.res;
          end
          default: begin
          end
        endcase
      end
      S_MEM: begin
        wb_en  = 1'b1;
        wb_val = ld_val;
        // POP into the stack pointer: popped value plus one in one write
        if ((op == trc16_pkg::OP_POP) && (rd == trc16_pkg::SP_IDX)) begin
          wb_val = ld_val + 16'd1;
        end
      end
      S_WB2: begin
        wb_en  = 1'b1;
        wb_idx = trc16_pkg::SP_IDX;
        wb_val = daddr + 16'd1;
      end
      default: begin
      end
    endcase
    rreq.we    = wb_en && (wb_idx != trc16_pkg::PC_IDX);
    rreq.waddr = wb_idx;
    rreq.wdata = wb_val;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      pc              <= 16'd0;
      z               <= 1'b0;
      c               <= 1'b0;
      done            <= 1'b0;
      halted          <= 1'b0;
      input_port_used <= trc16_pkg::PORT_NONE;
      output_port     <= trc16_pkg::PORT_NONE;
      output_value    <= 16'd0;
    end else begin
      done <= 1'b0;
      if (wb_en && (wb_idx == trc16_pkg::PC_IDX)) begin
        pc <= wb_val;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            halted          <= 1'b0;
            input_port_used <= trc16_pkg::PORT_NONE;
            output_port     <= trc16_pkg::PORT_NONE;
            output_value    <= 16'd0;
            io_val          <= io_in;
            if (!cmd) begin
              done <= 1'b1;
            end else begin
              rd_oor <= !trc16_pkg::in_range(pc);
              state  <= S_DECODE;
            end
          end
        end
        S_DECODE: begin
          ir <= word_in;
          if (word_in == trc16_pkg::HALT_WORD) begin
            halted <= 1'b1;
            done   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            pc    <= pc + 16'd1;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          done  <= 1'b1;
          state <= S_IDLE;
          case (op)
            trc16_pkg::OP_JMP: begin
              if (take) begin
                pc <= pc + ofs;
              end
            end
            trc16_pkg::OP_LDR, trc16_pkg::OP_POP: begin
              daddr   <= ld_addr;
              rd_oor  <= !trc16_pkg::in_range(ld_addr);
              port_rd <= in_code(ld_addr);
              done    <= 1'b0;
              state   <= S_MEM;
            end
            trc16_pkg::OP_STR: begin
              output_port <= out_code(a);
              if (out_code(a) != trc16_pkg::PORT_NONE) begin
                output_value <= b;
              end
            end
            trc16_pkg::OP_PUSH: begin
              output_port <= out_code(sp_dec);
              if (out_code(sp_dec) != trc16_pkg::PORT_NONE) begin
                output_value <= push_data;
              end
            end
            trc16_pkg::OP_ADD, trc16_pkg::OP_ADDI, trc16_pkg::OP_SUB, trc16_pkg::OP_SUBI,
            trc16_pkg::OP_AND, trc16_pkg::OP_OR, trc16_pkg::OP_SHR, trc16_pkg::OP_SHL,
            trc16_pkg::OP_CMP: begin
              z <= alu.z;
              c <= alu.c;
            end
            default: begin
            end
          endcase
        end
        S_MEM: begin
          input_port_used <= port_rd;
          if ((op == trc16_pkg::OP_POP) && (rd != trc16_pkg::SP_IDX)) begin
            state <= S_WB2;
          end else begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_WB2: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
